// ===== rtl/xtea_block_cipher_core_macros.svh =====
// assertion macros shared by the rtl files
`ifndef XTEA_BLOCK_CIPHER_CORE_MACROS_SVH
`define XTEA_BLOCK_CIPHER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define XTEA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");
`define XTEA_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define XTEA_ASSERT(lbl, clk, rst_n, prop)
`define XTEA_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== rtl/xtea_pkg.sv =====
`default_nettype none

package xtea_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned KeyWords = 4;
  localparam int unsigned KeyIdxW = 2;

  localparam logic [WordW-1:0] DELTA = 32'h9E3779B9;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } cmd_e;

  typedef logic [KeyWords-1:0][WordW-1:0] key_t;

  typedef struct packed {
    cmd_e             cmd;
    logic [WordW-1:0] y;
    logic [WordW-1:0] z;
    logic [WordW-1:0] sum;
  } stage_t;

  function automatic logic [WordW-1:0] mix(input logic [WordW-1:0] v);
    mix = ((v << 4) ^ (v >> 5)) + v;
  endfunction

  function automatic logic [WordW-1:0] round_term(input logic [WordW-1:0] v,
                                                  input logic [WordW-1:0] sum,
                                                  input logic [WordW-1:0] key);
    round_term = mix(v) ^ (sum + key);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/xtea_req_if.sv =====
`default_nettype none

interface xtea_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] block_low_word;
  logic [31:0] block_high_word;

  modport source (output valid, command, block_low_word, block_high_word, input ready);
  modport sink (input valid, command, block_low_word, block_high_word, output ready);
endinterface

`default_nettype wire

// ===== rtl/xtea_rsp_if.sv =====
`default_nettype none

interface xtea_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_low_word;
  logic [31:0] out_high_word;

  modport source (output valid, out_low_word, out_high_word, input ready);
  modport sink (input valid, out_low_word, out_high_word, output ready);
endinterface

`default_nettype wire

// ===== rtl/xtea_block_cipher_core.sv =====
// channel  | dir | handshake   | payload
// req_i    | in  | valid/ready | command, block_low_word, block_high_word
// rsp_o    | out | valid/ready | out_low_word, out_high_word
// cfg      | in  | cfg_we_i    | cfg_idx_i selects key word, cfg_wdata_i
// one request per cycle unless the chain holds for a waiting response; path: input register, then
// ROUNDS cells of two registered half rounds each
// the last cell register is the response register
// while a response waits the chain holds; the input register still takes one request
// reset clears all valid bits and the key words to zero
`default_nettype none

`include "xtea_block_cipher_core_macros.svh"

module xtea_block_cipher_core #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [xtea_pkg::KeyIdxW-1:0]  cfg_idx_i,
  input  logic [xtea_pkg::WordW-1:0]    cfg_wdata_i,
  xtea_req_if.sink                      req_i,
  xtea_rsp_if.source                    rsp_o
);

  localparam logic [xtea_pkg::WordW-1:0] SumDecrypt =
    xtea_pkg::WordW'(64'(xtea_pkg::DELTA) * 64'(ROUNDS));

  xtea_pkg::key_t   key_q;
  logic             in_v_q;
  xtea_pkg::stage_t in_d, in_q;
  logic             en;
  logic             in_ready;

  logic             valid_c [ROUNDS+1];
  xtea_pkg::stage_t data_c  [ROUNDS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      key_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  assign en       = !valid_c[ROUNDS] || rsp_o.ready;
  assign in_ready = en || !in_v_q;
  assign req_i.ready = in_ready;

  always_comb begin
    in_d.cmd = xtea_pkg::cmd_e'(req_i.command);
    in_d.y   = req_i.block_low_word;
    in_d.z   = req_i.block_high_word;
    in_d.sum = (in_d.cmd == xtea_pkg::CMD_DECRYPT) ? SumDecrypt : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready) begin
      in_v_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && in_ready) begin
      in_q <= in_d;
    end
  end

  assign valid_c[0] = in_v_q;
  assign data_c[0]  = in_q;

  for (genvar k = 0; k < ROUNDS; k++) begin : g_cell
    xtea_round_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .key_i   (key_q),
      .valid_i (valid_c[k]),
      .data_i  (data_c[k]),
      .valid_o (valid_c[k+1]),
      .data_o  (data_c[k+1])
    );
  end

  assign rsp_o.valid         = valid_c[ROUNDS];
  assign rsp_o.out_low_word  = data_c[ROUNDS].y;
  assign rsp_o.out_high_word = data_c[ROUNDS].z;

  `XTEA_ASSERT(a_in_hold_on_stall, clk_i, rst_ni, (in_v_q && !en) |=> in_v_q)
  `XTEA_ASSERT(a_in_moves_on, clk_i, rst_ni, en |=> (valid_c[0] == $past(req_i.valid)))
  `XTEA_ASSERT_NEVER(a_empty_input_blocked, clk_i, rst_ni, !in_v_q && !req_i.ready)
  `XTEA_ASSERT(a_rsp_hold, clk_i, rst_ni,
               (rsp_o.valid && !rsp_o.ready) |=> rsp_o.valid)

endmodule

`default_nettype wire

// ===== rtl/xtea_round_cell.sv =====
`default_nettype none

`include "xtea_block_cipher_core_macros.svh"

module xtea_round_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  xtea_pkg::key_t  key_i,
  input  logic            valid_i,
  input  xtea_pkg::stage_t data_i,
  output logic            valid_o,
  output xtea_pkg::stage_t data_o
);

  logic             mid_v_q;
  logic             out_v_q;
  xtea_pkg::stage_t mid_d, mid_q;
  xtea_pkg::stage_t out_d, out_q;

  // first half round, sum steps here
  always_comb begin
    mid_d = data_i;
    case (data_i.cmd)
      xtea_pkg::CMD_ENCRYPT: begin
        mid_d.y   = data_i.y + xtea_pkg::round_term(data_i.z, data_i.sum,
                                                    key_i[data_i.sum[1:0]]);
        mid_d.sum = data_i.sum + xtea_pkg::DELTA;
      end
      xtea_pkg::CMD_DECRYPT: begin
        mid_d.z   = data_i.z - xtea_pkg::round_term(data_i.y, data_i.sum,
                                                    key_i[data_i.sum[12:11]]);
        mid_d.sum = data_i.sum - xtea_pkg::DELTA;
      end
      default: ;
    endcase
  end

  // second half round
  always_comb begin
    out_d = mid_q;
    case (mid_q.cmd)
      xtea_pkg::CMD_ENCRYPT: begin
        out_d.z = mid_q.z + xtea_pkg::round_term(mid_q.y, mid_q.sum,
                                                 key_i[mid_q.sum[12:11]]);
      end
      xtea_pkg::CMD_DECRYPT: begin
        out_d.y = mid_q.y - xtea_pkg::round_term(mid_q.z, mid_q.sum,
                                                 key_i[mid_q.sum[1:0]]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en_i) begin
      mid_v_q <= valid_i;
      out_v_q <= mid_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_q <= mid_d;
      out_q <= out_d;
    end
  end

  assign valid_o = out_v_q;
  assign data_o  = out_q;

  `XTEA_ASSERT(a_mid_follows_in, clk_i, rst_ni, en_i |=> (mid_v_q == $past(valid_i)))
  `XTEA_ASSERT(a_out_follows_mid, clk_i, rst_ni, en_i |=> (out_v_q == $past(mid_v_q)))
  `XTEA_ASSERT(a_hold_on_stall, clk_i, rst_ni,
               !en_i |=> ($stable(mid_v_q) && $stable(out_v_q)))

endmodule

`default_nettype wire
